@@ rtl/lshp_pkg.sv @@
// Shared types and constants of the level-set hydrostatic pressure block.
`default_nettype none
package lshp_pkg;

    // Q16.16 one and the constants behind the quarter-wave sine table
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] INV_PI_Q32  = 64'd1367130551;

    // Register field widths
    localparam int HALF_WIDTH_W = 31;
    localparam int RECIP_W      = 32;
    localparam int DENSITY_W    = 27;
    localparam int GRAVITY_W    = 21;
    localparam int WEIGHT_W     = 17;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_HALF_WIDTH = 3'd0;
    localparam logic [2:0] REG_RECIP      = 3'd1;
    localparam logic [2:0] REG_WATER      = 3'd2;
    localparam logic [2:0] REG_AIR        = 3'd3;
    localparam logic [2:0] REG_GRAVITY    = 3'd4;

    // Reset values
    localparam logic [HALF_WIDTH_W-1:0] RST_HALF_WIDTH = 31'd5243;
    localparam logic [RECIP_W-1:0]      RST_RECIP      = 32'd819200;
    localparam logic [DENSITY_W-1:0]    RST_WATER      = 27'd65536000;
    localparam logic [DENSITY_W-1:0]    RST_AIR        = 27'd78971;
    localparam logic [GRAVITY_W-1:0]    RST_GRAVITY    = 21'd642908;

    typedef struct packed {
        logic [HALF_WIDTH_W-1:0] half_width;
        logic [RECIP_W-1:0]      recip;
        logic [DENSITY_W-1:0]    water;
        logic [DENSITY_W-1:0]    air;
        logic [GRAVITY_W-1:0]    gravity;
    } t_cfg;

    // What the weight pipeline hands to the density/pressure pipeline
    typedef struct packed {
        logic                neg;
        logic [31:0]         mag;
        logic [WEIGHT_W-1:0] weight;
    } t_wgt;

endpackage
`default_nettype wire

@@ rtl/lshp_regs.sv @@
// APB-style configuration register file.
`default_nettype none
module lshp_regs
    import lshp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_width <= RST_HALF_WIDTH;
            r_cfg.recip      <= RST_RECIP;
            r_cfg.water      <= RST_WATER;
            r_cfg.air        <= RST_AIR;
            r_cfg.gravity    <= RST_GRAVITY;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HALF_WIDTH: r_cfg.half_width <= pwdata[HALF_WIDTH_W-1:0];
                REG_RECIP:      r_cfg.recip      <= pwdata[RECIP_W-1:0];
                REG_WATER:      r_cfg.water      <= pwdata[DENSITY_W-1:0];
                REG_AIR:        r_cfg.air        <= pwdata[DENSITY_W-1:0];
                REG_GRAVITY:    r_cfg.gravity    <= pwdata[GRAVITY_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HALF_WIDTH: prdata = {1'b0, r_cfg.half_width};
            REG_RECIP:      prdata = r_cfg.recip;
            REG_WATER:      prdata = {5'd0, r_cfg.water};
            REG_AIR:        prdata = {5'd0, r_cfg.air};
            REG_GRAVITY:    prdata = {11'd0, r_cfg.gravity};
            default:        prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/lshp_weight.sv @@
// Five-stage pipeline from level-set distance to smoothed Heaviside weight.
`default_nettype none
module lshp_weight
    import lshp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_cfg             i_cfg,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_phi,
    output logic             o_ready,
    output logic             o_valid,
    output t_wgt             o_wgt,
    input  wire logic        i_dn_ready
);

    localparam int NS = 5;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = 16 + IW;

    typedef logic [15:0] t_sine_rom [SINE_TABLE_DEPTH+1];

    // sin(pi/2 * k / D) / pi in Q0.16, Taylor series to the 15th power
    function automatic logic [15:0] f_sine(input int unsigned k);
        logic [63:0]        a;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        a = (PI_HALF_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        term = a;
        sum  = $signed(a);
        for (int n = 1; n <= 7; n++) begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        prod = 64'(sum) * INV_PI_Q32 + (64'd1 << 45);
        return 16'(prod >> 46);
    endfunction

    function automatic t_sine_rom f_rom();
        t_sine_rom rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
            rom[k] = f_sine(k);
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_rom();

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    // Stage 0: band test and magnitude
    logic        r0_neg, r0_above, r0_below;
    logic [31:0] r0_mag;
    // Stage 1: distance times reciprocal
    logic        r1_neg, r1_above, r1_below;
    logic [31:0] r1_mag;
    logic [63:0] r1_prod;
    // Stage 2: normalized |x| and folded table coordinate
    logic        r2_neg, r2_above, r2_below;
    logic [31:0] r2_mag;
    logic [16:0] r2_xm;
    logic [15:0] r2_u;
    // Stage 3: table read
    logic        r3_neg, r3_above, r3_below;
    logic [31:0] r3_mag;
    logic [16:0] r3_xm;
    logic [15:0] r3_sine;
    // Stage 4: weight
    logic        r4_neg;
    logic [31:0] r4_mag;
    logic [16:0] r4_h;

    logic signed [32:0] w_phi, w_psi;
    logic [31:0]        w_mag;
    logic [64:0]        w_xsum;
    logic [47:0]        w_xsh;
    logic [16:0]        w_xm;
    logic [PW:0]        w_isum;
    logic [IW-1:0]      w_idx;
    logic signed [18:0] w_t;
    logic [18:0]        w_tc;
    logic [16:0]        w_h;

    // Advance a stage when it is empty or the one after it advances
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_dn_ready;
        for (int k = NS - 2; k >= 0; k--)
            w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NS-1];
    assign o_wgt   = '{neg: r4_neg, mag: r4_mag, weight: r4_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0])
                r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++)
                if (w_en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    assign w_phi = {i_phi[31], i_phi};
    assign w_psi = {2'b00, i_cfg.half_width};
    assign w_mag = i_phi[31] ? 32'(~i_phi + 32'd1) : i_phi;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_neg   <= i_phi[31];
            r0_mag   <= w_mag;
            r0_above <= w_phi > w_psi;
            r0_below <= w_phi < -w_psi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_neg   <= r0_neg;
            r1_above <= r0_above;
            r1_below <= r0_below;
            r1_mag   <= r0_mag;
            r1_prod  <= 64'(r0_mag) * 64'(i_cfg.recip);
        end
    end

    // Round, drop 16 fraction bits, saturate at one; fold onto the quarter wave
    assign w_xsum = 65'(r1_prod) + 65'd32768;
    assign w_xsh  = w_xsum[63:16];
    assign w_xm   = (w_xsh > 48'(ONE_Q16)) ? ONE_Q16 : w_xsh[16:0];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_neg   <= r1_neg;
            r2_above <= r1_above;
            r2_below <= r1_below;
            r2_mag   <= r1_mag;
            r2_xm    <= w_xm;
            r2_u     <= (w_xm > (ONE_Q16 >> 1)) ? 16'(ONE_Q16 - w_xm) : w_xm[15:0];
        end
    end

    // Nearest table entry
    assign w_isum = (PW+1)'(r2_u) * (PW+1)'(SINE_TABLE_DEPTH) + (PW+1)'(16384);
    assign w_idx  = w_isum[14+IW:15];

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_neg   <= r2_neg;
            r3_above <= r2_above;
            r3_below <= r2_below;
            r3_mag   <= r2_mag;
            r3_xm    <= r2_xm;
            r3_sine  <= SINE_ROM[w_idx];
        end
    end

    // t = 1 + x + sin(pi x)/pi, clamp to [0, 2], halve with rounding
    always_comb begin
        if (r3_neg)
            w_t = 19'sd65536 - $signed({2'b00, r3_xm}) - $signed({3'b000, r3_sine});
        else
            w_t = 19'sd65536 + $signed({2'b00, r3_xm}) + $signed({3'b000, r3_sine});
        if (w_t < 0)
            w_tc = 19'd0;
        else if (w_t > 19'sd131072)
            w_tc = 19'd131072;
        else
            w_tc = w_t;
        w_h = 17'((w_tc + 19'd1) >> 1);
        if (r3_above)
            w_h = ONE_Q16;
        else if (r3_below)
            w_h = 17'd0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_neg <= r3_neg;
            r4_mag <= r3_mag;
            r4_h   <= w_h;
        end
    end

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_vld == {NS{1'b1}}))
        else $error("upstream blocked while a stage is empty");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> (r4_h <= ONE_Q16))
        else $error("weight above one");

endmodule
`default_nettype wire

@@ rtl/lshp_mix.sv @@
// Six-stage pipeline from weight to blended density and pressure.
`default_nettype none
module lshp_mix
    import lshp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_cfg             i_cfg,
    input  wire logic        i_valid,
    input  t_wgt             i_wgt,
    output logic             o_ready,
    output logic             o_valid,
    output logic [63:0]      o_pressure,
    output logic [26:0]      o_mixed_density,
    output logic [16:0]      o_heaviside_weight,
    input  wire logic        i_dn_ready
);

    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    logic        r_neg [NS];
    logic [31:0] r_mag [2];
    logic [16:0] r_h   [NS];
    logic [26:0] r_rho [1:NS-1];

    logic [43:0] r0_pw, r0_pa;
    logic [58:0] r2_mprod;
    logic [42:0] r3_m;
    logic [63:0] r4_gprod;
    logic [63:0] r5_p;

    logic [44:0] w_rsum;
    logic [59:0] w_msum;
    logic [64:0] w_gsum;
    logic [47:0] w_pmag;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_dn_ready;
        for (int k = NS - 2; k >= 0; k--)
            w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign o_ready            = w_en[0];
    assign o_valid            = r_vld[NS-1];
    assign o_pressure         = r5_p;
    assign o_mixed_density    = r_rho[NS-1];
    assign o_heaviside_weight = r_h[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0])
                r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++)
                if (w_en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    // Carry sign, magnitude and weight down the stages
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_neg[0] <= i_wgt.neg;
            r_mag[0] <= i_wgt.mag;
            r_h[0]   <= i_wgt.weight;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_h[k]   <= r_h[k-1];
            end
        end
        if (w_en[1])
            r_mag[1] <= r_mag[0];
    end

    // Stage 0: weighted density products
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_pw <= 44'(i_cfg.water) * 44'(i_wgt.weight);
            r0_pa <= 44'(i_cfg.air) * 44'(ONE_Q16 - i_wgt.weight);
        end
    end

    // Stage 1: blended density, rounded
    assign w_rsum = 45'(r0_pw) + 45'(r0_pa) + 45'd32768;

    // Stage 2: distance times density
    // Stage 3: round to Q16.16
    assign w_msum = 60'(r2_mprod) + 60'd32768;

    // Stage 4: times gravity; stage 5: rounded, sign of the distance restored
    assign w_gsum = 65'(r4_gprod) + 65'd32768;
    assign w_pmag = w_gsum[63:16];

    always_ff @(posedge i_clk) begin
        if (w_en[1])
            r_rho[1] <= w_rsum[42:16];
        for (int k = 2; k < NS; k++)
            if (w_en[k])
                r_rho[k] <= r_rho[k-1];
        if (w_en[2])
            r2_mprod <= 59'(r_mag[1]) * 59'(r_rho[1]);
        if (w_en[3])
            r3_m <= w_msum[58:16];
        if (w_en[4])
            r4_gprod <= 64'(r3_m) * 64'(i_cfg.gravity);
        if (w_en[5])
            r5_p <= r_neg[4] ? 64'(~64'(w_pmag) + 64'd1) : 64'(w_pmag);
    end

    a_density_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mixed_density <= i_cfg.water) || (o_mixed_density <= i_cfg.air))
        else $error("blended density outside the two fluids");

    a_pressure_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_neg[NS-1]) |-> (o_pressure[63] || (o_pressure == 64'd0)))
        else $error("pressure sign does not follow the distance");

endmodule
`default_nettype wire

@@ rtl/level_set_hydrostatic_pressure.sv @@
// Top level of the level-set hydrostatic pressure block.
`default_nettype none
// Channel   Direction  Handshake                Payload
// cell in   input      i_valid / o_ready        i_level_set_value (Q16.16, signed)
// result    output     o_valid / i_ready        o_pressure, o_mixed_density,
//                                               o_heaviside_weight
// config    input      psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One cell per clock is sustained while the output is not stalled; each cell passes
// from its input transfer to its result through the 5-stage weight pipeline
// (band test, reciprocal multiply, normalize, sine table read, weight) and
// the 6-stage density/pressure pipeline.
// Synchronous active-low reset empties both pipelines and loads the register
// reset values; there is no memory to clear.
// A stall at the output holds only the stages that are full: empty stages
// keep filling, so input transfers continue until every stage holds a cell.
module level_set_hydrostatic_pressure
    import lshp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // cell input
    input  wire logic        i_valid,
    input  wire logic [31:0] i_level_set_value,
    output logic             o_ready,
    // result output
    output logic             o_valid,
    output logic [63:0]      o_pressure,
    output logic [26:0]      o_mixed_density,
    output logic [16:0]      o_heaviside_weight,
    input  wire logic        i_ready,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg w_cfg;
    t_wgt w_wgt;
    logic w_wgt_valid;
    logic w_mix_ready;

    // Registers: half-width, reciprocal, densities, gravity
    lshp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Distance to smoothed Heaviside weight
    lshp_weight #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_weight (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_valid),
        .i_phi      (i_level_set_value),
        .o_ready    (o_ready),
        .o_valid    (w_wgt_valid),
        .o_wgt      (w_wgt),
        .i_dn_ready (w_mix_ready)
    );

    // Weight to blended density and pressure; its last stage is the output register
    lshp_mix u_mix (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (w_cfg),
        .i_valid            (w_wgt_valid),
        .i_wgt              (w_wgt),
        .o_ready            (w_mix_ready),
        .o_valid            (o_valid),
        .o_pressure         (o_pressure),
        .o_mixed_density    (o_mixed_density),
        .o_heaviside_weight (o_heaviside_weight),
        .i_dn_ready         (i_ready)
    );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the level-set hydrostatic pressure block.
module testbench;
    import lshp_pkg::*;

    localparam int SINE_DEPTH        = 256;
    localparam int LATENCY           = 11;
    localparam int NUM_SETTINGS      = 8;
    localparam int CELLS_PER_SETTING = 125;
    localparam int HOLD_OFF_CYCLES   = 120;
    localparam int IDLE_PERCENT      = 27;
    localparam int CYCLE_LIMIT       = 100000;
    localparam int PLAN_ROWS         = 39;

    // Decoded by the block as no register at all; writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic [63:0] pressure;
        logic [26:0] density;
        logic [16:0] weight;
    } cell_result_t;

    typedef enum logic [1:0] {ROW_CELL, ROW_KNOWN, ROW_WRITE} row_kind_e;

    // One line of the directed plan: a cell (predicted or with its result typed
    // in) or a register write
    typedef struct packed {
        row_kind_e    kind;
        logic [2:0]   reg_idx;
        logic [31:0]  value;
        cell_result_t known;
    } plan_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_level_set_value = '0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_pressure;
    logic [26:0] o_mixed_density;
    logic [16:0] o_heaviside_weight;
    logic        i_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: a private copy of the registers and the sine/pi table
    t_cfg         cfg_model;
    logic [16:0]  sine_rom [0:SINE_DEPTH];
    cell_result_t cell_results_due [$];
    plan_row_t    directed_plan [PLAN_ROWS];

    // Side idling controls; the hold-off handshake is a pair of counters so that
    // the sink process alone times the stall
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;

    int unsigned cells_sent = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;

    level_set_hydrostatic_pressure #(
        .SINE_TABLE_DEPTH(SINE_DEPTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .i_level_set_value  (i_level_set_value),
        .o_ready            (o_ready),
        .o_valid            (o_valid),
        .o_pressure         (o_pressure),
        .o_mixed_density    (o_mixed_density),
        .o_heaviside_weight (o_heaviside_weight),
        .i_ready            (i_ready),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // sin(pi/2 * k / D) / pi in Q0.16: Taylor series to the 15th power in Q30,
    // truncating at every step, then scaled by 1/pi with rounding
    function automatic logic [16:0] quarter_sine_over_pi(input int unsigned k);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] scaled;
        longint      acc;
        int          n;
        a = (PI_HALF_Q30 * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
        term = a;
        acc = longint'(a);
        for (n = 1; n <= 7; n++) begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        scaled = (64'(acc) * INV_PI_Q32 + (64'd1 << 45)) >> 46;
        return scaled[16:0];
    endfunction

    // Weight, blended density and pressure of one cell under cfg_model
    function automatic cell_result_t cell_pressure(input logic [31:0] level);
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  xm;
        logic [63:0]  u;
        logic [63:0]  idx;
        logic [63:0]  w;
        logic [63:0]  rho;
        logic [63:0]  m;
        logic [63:0]  p;
        longint       phi;
        longint       psi;
        longint       x;
        longint       s;
        longint       t;
        cell_result_t r;
        neg = level[31];
        phi = longint'($signed(level));
        mag = neg ? (64'h1_0000_0000 - 64'(level)) : 64'(level);
        psi = longint'(cfg_model.half_width);
        if (phi > psi) begin
            w = 64'd65536;
        end else if (phi < -psi) begin
            w = 64'd0;
        end else begin
            // x = |phi| / psi through the reciprocal, rounded, capped at one
            xm = (mag * 64'(cfg_model.recip) + 64'd32768) >> 16;
            if (xm > 64'd65536) begin
                xm = 64'd65536;
            end
            // fold onto the rising quarter wave, take the nearest entry
            u = (xm > 64'd32768) ? (64'd65536 - xm) : xm;
            idx = (u * 64'(SINE_DEPTH) + 64'd16384) >> 15;
            if (idx > 64'(SINE_DEPTH)) begin
                idx = 64'(SINE_DEPTH);
            end
            s = longint'(sine_rom[idx]);
            x = longint'(xm);
            if (neg) begin
                s = -s;
                x = -x;
            end
            t = 65536 + x + s;
            if (t < 0) begin
                t = 0;
            end
            if (t > 131072) begin
                t = 131072;
            end
            w = 64'(t + 1) >> 1;
            if (w > 64'd65536) begin
                w = 64'd65536;
            end
        end
        rho = (64'(cfg_model.water) * w + 64'(cfg_model.air) * (64'd65536 - w)
               + 64'd32768) >> 16;
        m = (mag * rho + 64'd32768) >> 16;
        p = (m * 64'(cfg_model.gravity) + 64'd32768) >> 16;
        if (neg) begin
            p = -p;
        end
        r.pressure = p;
        r.density = rho[26:0];
        r.weight = w[16:0];
        return r;
    endfunction

    function automatic plan_row_t cell_row(input logic [31:0] value);
        plan_row_t r;
        r = '0;
        r.kind = ROW_CELL;
        r.value = value;
        return r;
    endfunction

    function automatic plan_row_t known_row(input logic [31:0] value, input logic [63:0] p,
                                            input logic [26:0] rho, input logic [16:0] w);
        plan_row_t r;
        r = '0;
        r.kind = ROW_KNOWN;
        r.value = value;
        r.known.pressure = p;
        r.known.density = rho;
        r.known.weight = w;
        return r;
    endfunction

    function automatic plan_row_t write_row(input logic [2:0] idx, input logic [31:0] value);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    // Random distance: a fifth anywhere in the 32-bit range, a tenth on the band
    // edges or at zero, the rest inside or just past the band
    function automatic logic [31:0] draw_cell();
        longint psi;
        longint v;
        psi = longint'(cfg_model.half_width);
        v = 0;
        case ($urandom_range(0, 9))
            0, 1: begin
                return $urandom;
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: v = psi;
                    1: v = -psi;
                    2: v = psi + 1;
                    3: v = -psi - 1;
                    4: v = psi - 1;
                    default: v = 0;
                endcase
            end
            default: begin
                v = longint'($urandom_range(0, 32'(psi + psi / 8 + 1)));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    // APB write: setup cycle, access cycle, then drop the select for a cycle
    // so that back-to-back writes never reassign psel within one step
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HALF_WIDTH: cfg_model.half_width = value[HALF_WIDTH_W-1:0];
            REG_RECIP:      cfg_model.recip = value[RECIP_W-1:0];
            REG_WATER:      cfg_model.water = value[DENSITY_W-1:0];
            REG_AIR:        cfg_model.air = value[DENSITY_W-1:0];
            REG_GRAVITY:    cfg_model.gravity = value[GRAVITY_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one cell and hold it until the transfer; valid stays high on exit so
    // the next cell can follow without a bubble
    task automatic send_cell(input logic [31:0] value, input bit is_known,
                             input cell_result_t known);
        if (!send_calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PERCENT);
        end
        i_valid <= 1'b1;
        i_level_set_value <= value;
        do @(posedge i_clk); while (!o_ready);
        cell_results_due.push_back(is_known ? known : cell_pressure(value));
        cells_sent++;
    endtask

    // Drop valid and wait for every outstanding result; every cell yields one,
    // so the block is idle once the queue is empty
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (cell_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Load one register setting: reset values, all maxima, all minima (but a half-width
    // of one), or a random one where the reciprocal usually matches the half-width
    task automatic pick_setting(input int unsigned n);
        logic [31:0] hw;
        logic [31:0] rc;
        logic [31:0] wa;
        logic [31:0] ai;
        logic [31:0] gr;
        case (n)
            0: begin
                hw = 32'(RST_HALF_WIDTH);
                rc = 32'(RST_RECIP);
                wa = 32'(RST_WATER);
                ai = 32'(RST_AIR);
                gr = 32'(RST_GRAVITY);
            end
            2: begin
                hw = 32'h7FFF_FFFF;
                rc = 32'hFFFF_FFFF;
                wa = 32'h07FF_FFFF;
                ai = 32'h07FF_FFFF;
                gr = 32'h001F_FFFF;
            end
            3: begin
                hw = 32'd1;
                rc = 32'd0;
                wa = 32'd0;
                ai = 32'd0;
                gr = 32'd0;
            end
            default: begin
                hw = $urandom >> $urandom_range(1, 31);
                if (hw != 0 && $urandom_range(0, 3) != 0) begin
                    rc = (hw == 1) ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / 64'(hw));
                end else begin
                    rc = $urandom;
                end
                // full 32-bit words: the block keeps only the register width
                wa = $urandom;
                ai = $urandom;
                gr = $urandom;
            end
        endcase
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_RECIP, rc);
        write_reg(REG_WATER, wa);
        write_reg(REG_AIR, ai);
        write_reg(REG_GRAVITY, gr);
    endtask

    // Result sink: check every transfer against the oldest expectation, then
    // pick ready for the next edge (random, calm, or a long hold-off)
    initial begin : result_sink
        cell_result_t want;
        int unsigned  hold_left;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                results_seen++;
                if (cell_results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, pressure %h", $time,
                             o_pressure);
                end else begin
                    want = cell_results_due.pop_front();
                    if (o_pressure !== want.pressure) begin
                        errors++;
                        $display("%0t: pressure expected %h, got %h", $time,
                                 want.pressure, o_pressure);
                    end
                    if (o_mixed_density !== want.density) begin
                        errors++;
                        $display("%0t: mixed density expected %0d, got %0d", $time,
                                 want.density, o_mixed_density);
                    end
                    if (o_heaviside_weight !== want.weight) begin
                        errors++;
                        $display("%0t: weight expected %0d, got %0d", $time,
                                 want.weight, o_heaviside_weight);
                    end
                end
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (recv_calm) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Cycle limit: far beyond the slowest legal run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: no completion within %0d cycles", $time, CYCLE_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : stimulus
        int unsigned k;
        int unsigned n;
        for (k = 0; k <= SINE_DEPTH; k++) begin
            sine_rom[k] = quarter_sine_over_pi(k);
        end
        cfg_model.half_width = RST_HALF_WIDTH;
        cfg_model.recip = RST_RECIP;
        cfg_model.water = RST_WATER;
        cfg_model.air = RST_AIR;
        cfg_model.gravity = RST_GRAVITY;

        // Directed plan. Typed-in results are the ones that need no arithmetic:
        // the centre of the band at reset, and the unit setting (half-width,
        // reciprocal, water and gravity all one, air zero) where pressure equals
        // the distance above the band and everything is zero below it.
        directed_plan = '{
            known_row(32'd0, 64'd0, 27'd32807486, 17'd32768),
            cell_row(32'h7FFF_FFFF),
            cell_row(32'h8000_0000),
            cell_row(32'd5243),           // exactly on the upper band edge
            cell_row(-32'd5243),          // exactly on the lower band edge
            cell_row(32'd5244),
            cell_row(-32'd5244),
            write_row(REG_HALF_WIDTH, 32'd65536),
            write_row(REG_RECIP, 32'd65536),
            write_row(REG_WATER, 32'd65536),
            write_row(REG_AIR, 32'd0),
            write_row(REG_GRAVITY, 32'd65536),
            known_row(32'h7FFF_FFFF, 64'h7FFF_FFFF, 27'd65536, 17'd65536),
            known_row(32'h8000_0000, 64'd0, 27'd0, 17'd0),
            known_row(32'd0, 64'd0, 27'd32768, 17'd32768),
            known_row(32'd65536, 64'd65536, 27'd65536, 17'd65536),
            known_row(-32'd65536, 64'd0, 27'd0, 17'd0),
            cell_row(32'd32768),          // quarter-wave peak
            cell_row(-32'd32768),
            cell_row(32'd16384),
            // zero reciprocal: x collapses to zero inside the band
            write_row(REG_RECIP, 32'd0),
            cell_row(32'd40000),
            // reciprocal far too large for the half-width: x saturates
            write_row(REG_RECIP, 32'hFFFF_FFFF),
            cell_row(32'd1),
            cell_row(32'hFFFF_FFFF),
            // zero half-width: only a zero distance reaches the formula
            write_row(REG_HALF_WIDTH, 32'd0),
            write_row(REG_RECIP, 32'd65536),
            known_row(32'd0, 64'd0, 27'd32768, 17'd32768),
            known_row(32'd1, 64'd1, 27'd65536, 17'd65536),
            known_row(32'hFFFF_FFFF, 64'd0, 27'd0, 17'd0),
            // write past the last register is dropped; the rest are masked
            write_row(REG_UNUSED, 32'hFFFF_FFFF),
            write_row(REG_HALF_WIDTH, 32'hFFFF_FFFF),
            write_row(REG_WATER, 32'hFFFF_FFFF),
            write_row(REG_AIR, 32'hFFFF_FFFF),
            write_row(REG_GRAVITY, 32'hFFFF_FFFF),
            cell_row(32'h7FFF_FFFF),
            cell_row(32'h8000_0000),
            cell_row(32'h4000_0000),
            cell_row(32'hC000_0000)
        };

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            case (directed_plan[i].kind)
                ROW_WRITE: begin
                    quiesce();
                    write_reg(directed_plan[i].reg_idx, directed_plan[i].value);
                end
                ROW_KNOWN: send_cell(directed_plan[i].value, 1'b1, directed_plan[i].known);
                default:   send_cell(directed_plan[i].value, 1'b0, '0);
            endcase
        end

        // Random part, one register setting per block of cells. Setting 1 runs
        // the sender flat out against a long receiver hold-off so the pipeline
        // fills and stalls the input; setting 5 runs both sides without idling.
        for (n = 0; n < NUM_SETTINGS; n++) begin
            quiesce();
            pick_setting(n);
            send_calm = (n == 1) || (n == 5);
            recv_calm = (n == 5);
            if (n == 1) begin
                hold_requests++;
            end
            for (k = 0; k < CELLS_PER_SETTING; k++) begin
                send_cell(draw_cell(), 1'b0, '0);
            end
        end

        // Drain, then watch a little longer for stray results
        quiesce();
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Covered %0d cells (%0d directed) and %0d results over %0d random settings,",
                 cells_sent, PLAN_ROWS - 14, results_seen, NUM_SETTINGS);
        $display("band edges, saturated and zero reciprocal, zero half-width and input stalls.");
        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
